// ===== hdl/hpmru_pkg.sv =====
// Shared types and constants for the binary16 round-up multiplier.
// No dependencies; used by every module of the block by scoped names.
`timescale 1ns / 1ps

package hpmru_pkg;

   localparam int WordWidth   = 16;
   localparam int ExpWidth    = 5;
   localparam int FracWidth   = 10;
   localparam int SigWidth    = FracWidth + 1;
   localparam int RawWidth    = 2 * SigWidth;
   localparam int LeadWidth   = 5;
   localparam int SumWidth    = 7;
   localparam int ShiftWidth  = 5;
   localparam int MagWidth    = RawWidth + 1;

   localparam logic [FracWidth-1:0] FRAC_ZERO = '0;
   localparam logic [ExpWidth-1:0]  EXP_ALL   = 5'h1F;
   localparam logic [ExpWidth-1:0]  EXP_ZERO  = 5'h00;

   localparam logic [WordWidth-2:0] POS_INF_MAG    = 15'h7C00;
   localparam logic [WordWidth-1:0] POS_INF        = 16'h7C00;
   localparam logic [WordWidth-1:0] NEG_MAX_FINITE = 16'hFBFF;

   // Normal range starts where the sum of lead position and biased
   // exponents reaches this value; the subnormal shift is taken from 26.
   localparam logic [SumWidth-1:0]    NORMAL_SUM_MIN = 7'd36;
   localparam logic [LeadWidth-1:0]   LEAD_NORM      = 5'd10;
   localparam logic [ShiftWidth+1:0]  TINY_SHIFT_REF = 7'd26;

   // Decoded view of one operand.
   typedef struct packed {
      logic                sign;
      logic                is_nan;
      logic                is_inf;
      logic                is_zero;
      logic [SigWidth-1:0] sig;
      logic [ExpWidth-1:0] xexp;
   } operand_class_type;

   // One result beat.
   typedef struct packed {
      logic [WordWidth-1:0] product;
      logic                 invalid;
      logic [RawWidth-1:0]  raw_significand;
      logic                 guard_bit;
      logic                 round_bit;
      logic                 sticky_bit;
      logic                 rounded_up;
   } result_type;

endpackage

// ===== hdl/hpmru_classify.sv =====
// Operand decoder: splits a binary16 word into sign, class, significand and
// effective exponent. Depends on hpmru_pkg.
`timescale 1ns / 1ps

module hpmru_classify (
   input  logic [hpmru_pkg::WordWidth-1:0] operand,
   output hpmru_pkg::operand_class_type    decoded
);

   logic [hpmru_pkg::ExpWidth-1:0]  exp_field;
   logic [hpmru_pkg::FracWidth-1:0] frac_field;
   logic                            exp_nonzero;

   assign exp_field   = operand[hpmru_pkg::WordWidth-2:hpmru_pkg::FracWidth];
   assign frac_field  = operand[hpmru_pkg::FracWidth-1:0];
   assign exp_nonzero = (exp_field != hpmru_pkg::EXP_ZERO);

   always_comb begin
      decoded.sign    = operand[hpmru_pkg::WordWidth-1];
      decoded.is_nan  = (exp_field == hpmru_pkg::EXP_ALL) && (frac_field != hpmru_pkg::FRAC_ZERO);
      decoded.is_inf  = (exp_field == hpmru_pkg::EXP_ALL) && (frac_field == hpmru_pkg::FRAC_ZERO);
      decoded.is_zero = !exp_nonzero && (frac_field == hpmru_pkg::FRAC_ZERO);
      decoded.sig     = {exp_nonzero, frac_field};
      // Subnormals behave as exponent one with no hidden bit.
      decoded.xexp    = exp_nonzero ? exp_field : hpmru_pkg::ExpWidth'(1);
   end

endmodule

// ===== hdl/hpmru_datapath.sv =====
// Multiply, normalize and round-toward-positive logic for one operand pair.
// Depends on hpmru_pkg; fed by two hpmru_classify instances.
`timescale 1ns / 1ps

module hpmru_datapath (
   input  hpmru_pkg::operand_class_type op_a,
   input  hpmru_pkg::operand_class_type op_b,
   output hpmru_pkg::result_type        result
);

   logic                                sign;
   logic                                invalid_case;
   logic                                inf_case;
   logic                                zero_case;
   logic [hpmru_pkg::RawWidth-1:0]      raw;
   logic [hpmru_pkg::LeadWidth-1:0]     lead;
   logic [hpmru_pkg::ExpWidth:0]        exp_pair;
   logic [hpmru_pkg::SumWidth-1:0]      lead_sum;
   logic                                normal_range;
   logic [hpmru_pkg::ShiftWidth-1:0]    shift;
   logic [hpmru_pkg::ShiftWidth-1:0]    shift_m2;
   logic [hpmru_pkg::RawWidth+1:0]      shifted;
   logic [hpmru_pkg::RawWidth-1:0]      kept;
   logic [hpmru_pkg::RawWidth-1:0]      low_mask;
   logic                                guard;
   logic                                rnd;
   logic                                sticky;
   logic                                up;
   logic [hpmru_pkg::SumWidth-1:0]      exp_m1;
   logic [hpmru_pkg::MagWidth-1:0]      mag;
   logic [hpmru_pkg::WordWidth-1:0]     finite_word;

   assign sign         = op_a.sign ^ op_b.sign;
   assign invalid_case = op_a.is_nan || op_b.is_nan || (op_a.is_inf && op_b.is_zero)
                         || (op_a.is_zero && op_b.is_inf);
   assign inf_case     = op_a.is_inf || op_b.is_inf;
   assign zero_case    = op_a.is_zero || op_b.is_zero;

   assign raw = hpmru_pkg::RawWidth'(op_a.sig) * hpmru_pkg::RawWidth'(op_b.sig);

   // Priority encoder for the leading one of the raw product.
   always_comb begin
      lead = '0;
      for (int i = 0; i < hpmru_pkg::RawWidth; i++) begin
         if (raw[i]) begin
            lead = hpmru_pkg::LeadWidth'(i);
         end
      end
   end

   assign exp_pair     = {1'b0, op_a.xexp} + {1'b0, op_b.xexp};
   assign lead_sum     = hpmru_pkg::SumWidth'(lead) + hpmru_pkg::SumWidth'(exp_pair);
   assign normal_range = (lead_sum >= hpmru_pkg::NORMAL_SUM_MIN);

   always_comb begin
      if (normal_range) begin
         shift  = (lead >= hpmru_pkg::LEAD_NORM) ?
                  hpmru_pkg::ShiftWidth'(lead - hpmru_pkg::LEAD_NORM) : '0;
         exp_m1 = lead_sum - hpmru_pkg::NORMAL_SUM_MIN;
      end else begin
         shift  = (hpmru_pkg::SumWidth'(exp_pair) <= hpmru_pkg::TINY_SHIFT_REF) ?
                  hpmru_pkg::ShiftWidth'(hpmru_pkg::TINY_SHIFT_REF
                                         - hpmru_pkg::SumWidth'(exp_pair)) : '0;
         exp_m1 = '0;
      end
   end

   // Two zero bits below the product catch guard and round in one shift.
   assign shifted  = {raw, 2'b00} >> shift;
   assign kept     = shifted[hpmru_pkg::RawWidth+1:2];
   assign guard    = shifted[1];
   assign rnd      = shifted[0];
   assign shift_m2 = shift - hpmru_pkg::ShiftWidth'(2);
   assign low_mask = ~({hpmru_pkg::RawWidth{1'b1}} << shift_m2);
   assign sticky   = (shift >= hpmru_pkg::ShiftWidth'(3)) && ((raw & low_mask) != '0);
   assign up       = (guard || rnd || sticky) && !sign;

   // The exponent field sits in the same sum so a rounding carry moves it.
   assign mag = {hpmru_pkg::MagWidth'(exp_m1) << hpmru_pkg::FracWidth}
                + hpmru_pkg::MagWidth'(kept) + hpmru_pkg::MagWidth'(up);

   always_comb begin
      if (mag >= hpmru_pkg::MagWidth'(hpmru_pkg::POS_INF_MAG)) begin
         finite_word = sign ? hpmru_pkg::NEG_MAX_FINITE : hpmru_pkg::POS_INF;
      end else begin
         finite_word = {sign, mag[hpmru_pkg::WordWidth-2:0]};
      end
   end

   always_comb begin
      result = '0;
      if (invalid_case) begin
         result.invalid = 1'b1;
      end else if (inf_case) begin
         result.product = {sign, hpmru_pkg::POS_INF_MAG};
      end else if (zero_case) begin
         result.product = {sign, {(hpmru_pkg::WordWidth-1){1'b0}}};
      end else begin
         result.product         = finite_word;
         result.raw_significand = raw;
         result.guard_bit       = guard;
         result.round_bit       = rnd;
         result.sticky_bit      = sticky;
         result.rounded_up      = up;
      end
   end

endmodule

// ===== hdl/half_precision_multiplier_round_up_core.sv =====
// Top level of the binary16 multiplier with rounding toward positive infinity.
// Depends on hpmru_pkg, hpmru_classify and hpmru_datapath.
`timescale 1ns / 1ps

//  Channel | Ports                                   | Direction | Beat
//  --------+-----------------------------------------+-----------+------------------------
//  req     | req_valid, req_stall, req_operand_a/b   | in        | one operand pair
//  rsp     | rsp_valid, rsp_stall, rsp_product, ...  | out       | product and rounding info
//
//  Each beat passes through the operand register and then the result
//  register: rsp_valid rises when the beat is loaded into the result register,
//  and the result beat leaves once rsp_stall is low.
//  A new request beat can be taken every cycle while req_stall is low; the throughput is set by the
//  single pass through the 11x11 multiplier and the normalize/round logic.
//  Reset clears only the two stage valid flags; payload registers are not reset.
//  When rsp_stall holds a result, the operand stage may still fill, after which
//  req_stall rises until the result beat leaves.

module half_precision_multiplier_round_up_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_operand_a,
   input  logic [15:0] req_operand_b,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_product,
   output logic        rsp_invalid,
   output logic [21:0] rsp_raw_significand,
   output logic        rsp_guard_bit,
   output logic        rsp_round_bit,
   output logic        rsp_sticky_bit,
   output logic        rsp_rounded_up
);

   // Operand stage.
   logic                                   stage_valid_ff;
   logic                                   stage_valid_in;
   logic [hpmru_pkg::WordWidth-1:0]        operand_a_ff;
   logic [hpmru_pkg::WordWidth-1:0]        operand_b_ff;

   // Result stage.
   logic                                   result_valid_ff;
   logic                                   result_valid_in;
   hpmru_pkg::result_type                  result_ff;
   hpmru_pkg::result_type                  result_in;

   hpmru_pkg::operand_class_type           class_a;
   hpmru_pkg::operand_class_type           class_b;

   logic                                   out_open;
   logic                                   in_open;

   // The result register can load when it is empty or its beat is leaving;
   // the operand register can load when it is empty or moves forward.
   assign out_open  = !result_valid_ff || !rsp_stall;
   assign in_open   = !stage_valid_ff || out_open;
   assign req_stall = !in_open;

   assign stage_valid_in  = in_open  ? req_valid      : stage_valid_ff;
   assign result_valid_in = out_open ? stage_valid_ff : result_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff  <= 1'b0;
         result_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff  <= stage_valid_in;
         result_valid_ff <= result_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_open && req_valid) begin
         operand_a_ff <= req_operand_a;
         operand_b_ff <= req_operand_b;
      end
      if (out_open && stage_valid_ff) begin
         result_ff <= result_in;
      end
   end

   hpmru_classify u_classify_a (
      .operand (operand_a_ff),
      .decoded (class_a)
   );

   hpmru_classify u_classify_b (
      .operand (operand_b_ff),
      .decoded (class_b)
   );

   hpmru_datapath u_datapath (
      .op_a   (class_a),
      .op_b   (class_b),
      .result (result_in)
   );

   assign rsp_valid           = result_valid_ff;
   assign rsp_product         = result_ff.product;
   assign rsp_invalid         = result_ff.invalid;
   assign rsp_raw_significand = result_ff.raw_significand;
   assign rsp_guard_bit       = result_ff.guard_bit;
   assign rsp_round_bit       = result_ff.round_bit;
   assign rsp_sticky_bit      = result_ff.sticky_bit;
   assign rsp_rounded_up      = result_ff.rounded_up;

endmodule
